// File: sv/vccfc_pkg.sv
// ----------------------------------------------------------------------------
// vccfc_pkg
// Shared types and constants for the credit-based virtual channel flow control.
// ----------------------------------------------------------------------------
package vccfc_pkg;

	localparam int VC_MAX     = 8;
	localparam int CREDIT_MAX = 15;
	localparam int VC_W       = $clog2(VC_MAX);
	localparam int CNT_W      = 4;
	localparam int CRED_W     = 4;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [CNT_W-1:0]  VC_COUNT_RST     = 4'd4;
	localparam logic [CRED_W-1:0] BUFFER_DEPTH_RST = 4'd4;

	typedef enum logic {
		REG_VC_COUNT     = 1'b0,
		REG_BUFFER_DEPTH = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CH_IDLE   = 2'd0,
		CH_ACTIVE = 2'd1,
		CH_WAIT   = 2'd2
	} ch_state_t;

	typedef struct packed {
		logic            credit_valid;
		logic [VC_W-1:0] credit_vc;
		logic            credit_tail;
		logic            flit_ready;
		logic            flit_is_head;
	} in_item_t;

	typedef struct packed {
		logic            flit_sent;
		logic [VC_W-1:0] sent_vc;
		logic            alloc_failed;
	} out_item_t;

endpackage

// File: sv/vc_credit_flow_control.sv
// ----------------------------------------------------------------------------
// vc_credit_flow_control
// Output side of a network terminal with credit-based virtual channels.
// ----------------------------------------------------------------------------
// Each input transaction on in_data carries a batch of events: an
// optional returned credit and the state of the front flit of the source
// queue. It produces exactly one output transaction on out_data telling
// whether the flit left, on which channel, and whether a head flit found no
// idle channel. The credit is applied before the flit is considered.
// An accepted transaction is held in an input register and resolved against
// the channel table, and the result register captures the outcome when it
// is empty or being taken; out_valid shows the result register. One
// transaction is taken every cycle while the receiver does not stall; the
// table update keeps consecutive transactions back to back.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; in_stall rises only when both are full.
// Reset leaves all channels idle with four credits, vc_count at four and
// buffer_depth at four. The user must write the registers over the APB port only
// while no transaction is in flight (unenforced); buffer_depth writes reload all credits.
module vc_credit_flow_control (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  vccfc_pkg::in_item_t        in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output vccfc_pkg::out_item_t       out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vccfc_pkg::ADDR_W-1:0] paddr,
	input  logic [vccfc_pkg::DATA_W-1:0] pwdata,
	output logic [vccfc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import vccfc_pkg::*;

	logic                  s1_valid_s1;
	in_item_t              s1_data_s1;
	logic                  s2_valid_s2;
	out_item_t             s2_data_s2;
	logic                  s2_ready;
	logic                  advance;

	logic [CNT_W-1:0]      vc_count_q;
	logic [CRED_W-1:0]     buffer_depth_q;
	ch_state_t             state_q [VC_MAX];
	logic [CRED_W-1:0]     credit_q [VC_MAX];
	logic [VC_W-1:0]       cur_q;

	ch_state_t             state_n [VC_MAX];
	logic [CRED_W-1:0]     credit_n [VC_MAX];
	logic [VC_W-1:0]       cur_n;
	out_item_t             result;
	logic [CNT_W-1:0]      used;
	logic [CRED_W-1:0]     limit;
	logic                  go;
	logic                  found;
	logic                  cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		if (paddr[2] == REG_BUFFER_DEPTH) begin
			prdata = {{(DATA_W-CRED_W){1'b0}}, buffer_depth_q};
		end else begin
			prdata = {{(DATA_W-CNT_W){1'b0}}, vc_count_q};
		end
	end

	assign s2_ready  = !s2_valid_s2 || !out_stall;
	assign in_stall  = s1_valid_s1 && !s2_ready;
	assign advance   = s1_valid_s1 && s2_ready;
	assign out_valid = s2_valid_s2;
	assign out_data  = s2_data_s2;

	assign used  = (vc_count_q > CNT_W'(VC_MAX)) ? CNT_W'(VC_MAX) : vc_count_q;
	assign limit = (buffer_depth_q > CRED_W'(CREDIT_MAX)) ? CRED_W'(CREDIT_MAX)
		: buffer_depth_q;

	always_comb begin
		for (int i = 0; i < VC_MAX; i++) begin
			state_n[i]  = state_q[i];
			credit_n[i] = credit_q[i];
		end
		cur_n  = cur_q;
		go     = 1'b0;
		found  = 1'b0;
		result = '0;

		if (s1_data_s1.credit_valid) begin
			if (credit_n[s1_data_s1.credit_vc] < limit) begin
				credit_n[s1_data_s1.credit_vc] = credit_n[s1_data_s1.credit_vc] + 1'b1;
			end
			if (state_n[s1_data_s1.credit_vc] == CH_WAIT) begin
				state_n[s1_data_s1.credit_vc] = CH_ACTIVE;
			end
			if (s1_data_s1.credit_tail) begin
				state_n[s1_data_s1.credit_vc] = CH_IDLE;
			end
		end

		if (s1_data_s1.flit_ready) begin
			if (s1_data_s1.flit_is_head) begin
				for (int i = 0; i < VC_MAX; i++) begin
					if (!found && (CNT_W'(i) < used) && state_n[i] == CH_IDLE) begin
						found      = 1'b1;
						cur_n      = VC_W'(i);
						state_n[i] = CH_ACTIVE;
					end
				end
				go                  = found;
				result.alloc_failed = !found;
			end else if (state_n[cur_n] == CH_ACTIVE) begin
				go = 1'b1;
			end
		end

		if (go) begin
			if (credit_n[cur_n] != '0) begin
				credit_n[cur_n] = credit_n[cur_n] - 1'b1;
			end
			if (credit_n[cur_n] == '0) begin
				state_n[cur_n] = CH_WAIT;
			end
			result.flit_sent = 1'b1;
			result.sent_vc   = cur_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			s1_data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			s2_valid_s2 <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s2_data_s2 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_count_q     <= VC_COUNT_RST;
			buffer_depth_q <= BUFFER_DEPTH_RST;
			cur_q          <= '0;
			for (int i = 0; i < VC_MAX; i++) begin
				state_q[i]  <= CH_IDLE;
				credit_q[i] <= BUFFER_DEPTH_RST;
			end
		end else if (cfg_write) begin
			if (paddr[2] == REG_BUFFER_DEPTH) begin
				buffer_depth_q <= pwdata[CRED_W-1:0];
				for (int i = 0; i < VC_MAX; i++) begin
					credit_q[i] <= (pwdata[CRED_W-1:0] > CRED_W'(CREDIT_MAX))
						? CRED_W'(CREDIT_MAX) : pwdata[CRED_W-1:0];
				end
			end else begin
				vc_count_q <= pwdata[CNT_W-1:0];
			end
		end else if (advance) begin
			cur_q <= cur_n;
			for (int i = 0; i < VC_MAX; i++) begin
				state_q[i]  <= state_n[i];
				credit_q[i] <= credit_n[i];
			end
		end
	end

endmodule

// File: sv/vccfc_checker.sv
// ----------------------------------------------------------------------------
// vccfc_checker
// Port-level checks for the credit-based virtual channel flow control.
// ----------------------------------------------------------------------------
module vccfc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  vccfc_pkg::out_item_t         out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vccfc_pkg::ADDR_W-1:0] paddr,
	input  logic [vccfc_pkg::DATA_W-1:0] pwdata,
	input  logic [vccfc_pkg::DATA_W-1:0] prdata
);
	import vccfc_pkg::*;

	// A stalled output transaction must stay in place unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// A flit that was not sent carries channel zero.
	a_idle_vc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.flit_sent |-> out_data.sent_vc == '0)
		else $error("sent_vc nonzero without a sent flit");

	// A failed allocation never sends a flit.
	a_fail_nosend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.alloc_failed |-> !out_data.flit_sent)
		else $error("flit sent although allocation failed");

	// A read of vc_count right after a write to it returns the written value.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite && paddr[2] == REG_VC_COUNT) &&
		psel && !pwrite && paddr[2] == REG_VC_COUNT
		|-> prdata == {{(DATA_W-CNT_W){1'b0}}, $past(pwdata[CNT_W-1:0])})
		else $error("vc_count readback mismatch");

endmodule

bind vc_credit_flow_control vccfc_checker u_vccfc_checker (.*);
